>>> hdl/fdes_pkg.sv
// Shared types, constants and round functions for the Feistel block cipher.
package fdes_pkg;

  localparam int ROUND_COUNT_DEFAULT = 16;
  localparam int KEY_COUNT           = 16;
  localparam int HALF_W              = 28;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CIPHER_KEY  = 2'd0,
    REG_CBC_ENABLE  = 2'd1,
    REG_INIT_VECTOR = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // cumulative key rotation for each round, mod 28
  localparam logic [4:0] ROT_TAB [KEY_COUNT] = '{
    5'd1, 5'd4, 5'd10, 5'd20, 5'd7, 5'd0, 5'd0, 5'd8,
    5'd25, 5'd24, 5'd6, 5'd0, 5'd7, 5'd0, 5'd8, 5'd4
  };

  localparam logic [3:0] SBOX [8][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] v,
                                                input logic [4:0] s);
    logic [2*HALF_W-1:0] dbl;
    dbl = {v, v} << s;
    return dbl[2*HALF_W-1:HALF_W];
  endfunction

  function automatic logic [47:0] round_key(input logic [55:0] key,
                                            input logic [3:0] idx);
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    c = rotl28(key[55:28], ROT_TAB[idx]);
    d = rotl28(key[27:0], ROT_TAB[idx]);
    return {c[27:4], d[23:0]};
  endfunction

  function automatic logic [31:0] feistel_f(input logic [31:0] r,
                                            input logic [47:0] k);
    logic [33:0] w;
    logic [47:0] x;
    logic [5:0]  g;
    logic [31:0] o;
    w = {r[0], r, r[31]};
    for (int i = 0; i < 8; i++) begin
      x[6*i +: 6] = w[4*i +: 6];
    end
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      g = x[6*i +: 6];
      o[4*i +: 4] = SBOX[i][{g[5], g[0]}][g[4:1]];
    end
    return o;
  endfunction

endpackage

>>> hdl/fdes_ctrl.sv
// Sequencer for word acceptance, round stepping and the output register.
module fdes_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fdes_pkg::status_t st,
  output fdes_pkg::cmd_t  cmd
);
  import fdes_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.step   = (state == S_RUN);
  assign cmd.finish = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (cmd.load) state <= S_RUN;
        S_RUN:  if (st.last) state <= S_OUT;
        S_OUT:  if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/fdes_datapath.sv
// Round datapath, key schedule, chaining and configuration registers.
module fdes_datapath #(
  parameter int ROUND_COUNT = fdes_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fdes_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fdes_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                op,
  input  logic [63:0]                         data_block,
  input  logic                                first_block,
  input  fdes_pkg::cmd_t                      cmd,
  output fdes_pkg::status_t                   st,
  output logic [63:0]                         result_block
);
  import fdes_pkg::*;

  localparam int CW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [CW-1:0] LAST = CW'(ROUND_COUNT - 1);

  logic [55:0] cipher_key;
  logic        cbc_enable;
  logic [63:0] init_vector;
  logic [63:0] chain_block;

  logic [31:0] l;
  logic [31:0] r;
  logic [CW-1:0] cnt;
  logic        dec;
  logic [63:0] link;
  logic [63:0] saved_block;

  logic [63:0] link_next;
  logic [63:0] pre;
  logic [3:0]  kidx;
  logic [31:0] fout;
  logic [63:0] res_next;

  assign link_next = first_block ? init_vector : chain_block;
  assign pre       = data_block ^ (cbc_enable ? link_next : 64'd0);
  assign kidx      = dec ? 4'(LAST - cnt) : 4'(cnt);
  assign fout      = feistel_f(r, round_key(cipher_key, kidx));
  assign res_next  = dec ? ({r, l} ^ (cbc_enable ? link : 64'd0)) : {l, r};
  assign st.last   = (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key  <= '0;
      cbc_enable  <= 1'b0;
      init_vector <= '0;
      chain_block <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CIPHER_KEY:  cipher_key  <= cfg_data[55:0];
          REG_CBC_ENABLE:  cbc_enable  <= cfg_data[0];
          REG_INIT_VECTOR: init_vector <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        chain_block <= dec ? saved_block : res_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dec         <= op;
      link        <= link_next;
      saved_block <= data_block;
      cnt         <= '0;
      if (op) begin
        l <= data_block[31:0];
        r <= data_block[63:32];
      end else begin
        l <= pre[63:32];
        r <= pre[31:0];
      end
    end else if (cmd.step) begin
      l   <= r;
      r   <= l ^ fout;
      cnt <= cnt + 1'b1;
    end
    if (cmd.finish) begin
      result_block <= res_next;
    end
  end
endmodule

>>> hdl/feistel_des_variant_block_cipher.sv
// Top level of the Feistel block cipher: controller, datapath and checks.
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | op, data_block, first_block
//   out     | out       | out_valid/out_ready  | result_block
//
// After acceptance a word runs one round per cycle through the single round unit,
// then the result is loaded into the output register when the output is free.
// The next word is taken only once the controller is back in idle; words never overlap.
// Synchronous reset clears keys, mode, vector and chain to zero; cfg always ready.
// An output stall holds the finished word in the datapath until taken.
module feistel_des_variant_block_cipher #(
  parameter int ROUND_COUNT = fdes_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdes_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fdes_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [63:0]                       data_block,
  input  logic                              first_block,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [63:0]                       result_block
);
  import fdes_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  fdes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fdes_datapath #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .data_block  (data_block),
    .first_block (first_block),
    .cmd         (cmd),
    .st          (st),
    .result_block(result_block)
  );

`ifndef NO_ASSERTIONS
  a_load_not_step: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && (cmd.step || cmd.finish)))
    else $error("load overlaps round or output command");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready && cmd.step))
    else $error("rounds did not start after accepting a word");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && st.last) |=> (!cmd.step && !in_ready))
    else $error("rounds ran past the last one");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished word not presented");
`endif
endmodule
